FILE: rtl/ssu_pkg.sv
// Shared types, codes, widths and the output clip function of the state-space step unit.
package ssu_pkg;

  localparam int MAX_STATES  = 8;
  localparam int MAX_INPUTS  = 4;
  localparam int MAX_OUTPUTS = 4;
  localparam int VALUE_WIDTH = 24;
  localparam int FRAC_BITS   = 16;

  // Euler step size is an unsigned Q0.16 fraction.
  localparam int STEP_W    = 16;
  localparam int STEP_FRAC = 16;

  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;
  localparam int TERM_W = 4;

  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_STATES + MAX_INPUTS);
  localparam int RND_W  = ACC_W - FRAC_BITS + 1;
  localparam int EPROD_W = RND_W + STEP_W + 1;
  localparam int T_W     = EPROD_W + 1;
  localparam int CLIP_W  = T_W - STEP_FRAC;

  // Coefficient memory address is {matrix, row, column}.
  localparam int COEF_AW    = 2 + 2 * IDX_W;
  localparam int COEF_DEPTH = 1 << COEF_AW;
  // Vector memory address is {region, element}.
  localparam int VEC_AW    = 2 + IDX_W;
  localparam int VEC_DEPTH = 1 << VEC_AW;

  localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
  localparam logic [1:0] OP_WRITE_INPUT = 2'd1;
  localparam logic [1:0] OP_STEP        = 2'd2;
  localparam logic [1:0] OP_WRITE_STATE = 2'd3;

  localparam logic [1:0] MAT_A = 2'd0;
  localparam logic [1:0] MAT_B = 2'd1;
  localparam logic [1:0] MAT_C = 2'd2;
  localparam logic [1:0] MAT_D = 2'd3;

  localparam logic [1:0] VR_INPUT = 2'd0;
  localparam logic [1:0] VR_STATE = 2'd1;
  localparam logic [1:0] VR_STAGE = 2'd2;

  localparam logic [2:0] REG_STATES  = 3'd0;
  localparam logic [2:0] REG_INPUTS  = 3'd1;
  localparam logic [2:0] REG_OUTPUTS = 3'd2;
  localparam logic [2:0] REG_EULER   = 3'd3;
  localparam logic [2:0] REG_STEP    = 3'd4;

  localparam logic PH_OUT   = 1'b0;
  localparam logic PH_STATE = 1'b1;

  localparam logic [ACC_W:0] RND_HALF  = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [T_W-1:0] STEP_HALF = T_W'(1) << (STEP_FRAC - 1);

  localparam logic signed [CLIP_W-1:0] VMAX_C = CLIP_W'((1 << (VALUE_WIDTH - 1)) - 1);
  localparam logic signed [CLIP_W-1:0] VMIN_C = ~VMAX_C;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_ISSUE,
    ST_ROW_DRAIN,
    ST_FIN,
    ST_EU_MUL,
    ST_EU_SUM,
    ST_EMIT,
    ST_COPY,
    ST_COPY_END
  } ssu_state_t;

  typedef struct packed {
    logic                   sat;
    logic [VALUE_WIDTH-1:0] value;
  } clip_t;

  function automatic clip_t clip_value(input logic signed [CLIP_W-1:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.value = v[VALUE_WIDTH-1:0];
    if (v > VMAX_C) begin
      r.sat = 1'b1;
      r.value = VMAX_C[VALUE_WIDTH-1:0];
    end else if (v < VMIN_C) begin
      r.sat = 1'b1;
      r.value = VMIN_C[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/state_space_step_unit.sv
// Top level of the state-space step unit: coefficient and vector memories, MAC sequencer, output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tuser op,matrix_sel; tdata row,col,value
//  out_    | master    | out_tvalid/tready  | tuser kind; tdata index,value,sat; tlast
//  cfg_    | slave     | cfg_valid/ready    | cfg_index register, cfg_data value
//
// A step runs one row at a time on a single multiply-accumulate unit fed by the coefficient
// memory: each of the (outputs + states) rows sums (states + inputs) terms, Euler state rows
// add an update step, and a copy-back of the staged states ends the step.
// After reset a clearing pass zeroes both memories; no word is taken meanwhile.
// A full output register holds the sequencer in its emit state until out_tready.
module state_space_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index[2:0], col_index[5:3], item_value[29:6], zero fill
  input  logic [3:0]  in_tuser,   // op[1:0], matrix_sel[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_index[2:0], result_value[26:3], saturated[27], zero fill
  output logic [0:0]  out_tuser,  // result_kind[0]
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ssu_pkg::*;

  // Configuration registers.
  logic [3:0]        cfg_states_r;
  logic [2:0]        cfg_inputs_r;
  logic [2:0]        cfg_outputs_r;
  logic              cfg_euler_r;
  logic [STEP_W-1:0] cfg_step_r;

  ssu_state_t state_r, state_nxt;
  logic [COEF_AW-1:0] clr_cnt_r;
  logic               phase_r, phase_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [TERM_W-1:0]  term_r, term_nxt;
  logic [IDX_W-1:0]   cp_r, cp_nxt;
  logic               cp_v_r;
  logic [IDX_W-1:0]   cp_idx_r;

  logic issue, acc_clr, fin_round, eu_sum, out_load;

  // Memories and their registered read data.
  logic signed [VALUE_WIDTH-1:0] coef_mem [COEF_DEPTH];
  logic signed [VALUE_WIDTH-1:0] vec_mem  [VEC_DEPTH];
  logic signed [VALUE_WIDTH-1:0] coef_q_r, vec_q_r;
  logic [COEF_AW-1:0]            coef_raddr, coef_waddr;
  logic [VEC_AW-1:0]             vec_raddr, vec_waddr;
  logic                          coef_we, vec_we;
  logic signed [VALUE_WIDTH-1:0] coef_wdata, vec_wdata;

  // MAC pipeline.
  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Finishing arithmetic.
  logic [ACC_W:0]            rnd_sum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   dx_r;
  logic signed [EPROD_W-1:0] eprod_r;
  logic [T_W-1:0]            eu_t;
  logic signed [CLIP_W-1:0]  eu_v;
  clip_t                     clip_rnd, clip_eu;
  logic [VALUE_WIDTH-1:0]    res_value_r;
  logic                      res_sat_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_tdata_r;
  logic        out_kind_r;
  logic        out_last_r;

  // Input word fields.
  logic [1:0]                    in_op, in_sel;
  logic [IDX_W-1:0]              in_row, in_col;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic                          in_accept, coef_ok;

  // Active counts and row bookkeeping.
  logic [CNT_W-1:0]  ns_cnt, ni_cnt, no_cnt;
  logic [TERM_W-1:0] nterms, in_idx;
  logic              term_is_state, term_last, row_last, cp_last, out_free;
  logic [1:0]        term_mat;
  logic [IDX_W-1:0]  term_col;

  assign in_op  = in_tuser[1:0];
  assign in_sel = in_tuser[3:2];
  assign in_row = in_tdata[2:0];
  assign in_col = in_tdata[5:3];
  assign in_val = in_tdata[29:6];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_kind_r;
  assign out_tlast    = out_last_r;
  assign out_free     = !out_valid_r || out_tready;

  // Zero states act as one; counts above the maximum act as the maximum.
  always_comb begin
    if (cfg_states_r == '0) begin
      ns_cnt = CNT_W'(1);
    end else if (cfg_states_r > CNT_W'(MAX_STATES)) begin
      ns_cnt = CNT_W'(MAX_STATES);
    end else begin
      ns_cnt = cfg_states_r;
    end
    ni_cnt = ({1'b0, cfg_inputs_r} > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS)
                                                         : {1'b0, cfg_inputs_r};
    no_cnt = ({1'b0, cfg_outputs_r} > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS)
                                                           : {1'b0, cfg_outputs_r};
  end

  assign nterms        = ns_cnt + ni_cnt;
  assign term_is_state = (term_r < ns_cnt);
  assign in_idx        = term_r - ns_cnt;
  assign term_col      = term_is_state ? term_r[IDX_W-1:0] : in_idx[IDX_W-1:0];
  assign term_last     = ((term_r + TERM_W'(1)) == nterms);
  assign row_last      = (({1'b0, row_r} + CNT_W'(1)) ==
                          ((phase_r == PH_STATE) ? ns_cnt : no_cnt));
  assign cp_last       = (({1'b0, cp_r} + CNT_W'(1)) == ns_cnt);

  always_comb begin
    if (phase_r == PH_STATE) begin
      term_mat = term_is_state ? MAT_A : MAT_B;
    end else begin
      term_mat = term_is_state ? MAT_C : MAT_D;
    end
  end

  always_comb begin
    case (in_sel)
      MAT_A: coef_ok = ({1'b0, in_row} < CNT_W'(MAX_STATES)) &&
                       ({1'b0, in_col} < CNT_W'(MAX_STATES));
      MAT_B: coef_ok = ({1'b0, in_row} < CNT_W'(MAX_STATES)) &&
                       ({1'b0, in_col} < CNT_W'(MAX_INPUTS));
      MAT_C: coef_ok = ({1'b0, in_row} < CNT_W'(MAX_OUTPUTS)) &&
                       ({1'b0, in_col} < CNT_W'(MAX_STATES));
      default: coef_ok = ({1'b0, in_row} < CNT_W'(MAX_OUTPUTS)) &&
                         ({1'b0, in_col} < CNT_W'(MAX_INPUTS));
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    row_nxt   = row_r;
    term_nxt  = term_r;
    cp_nxt    = cp_r;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    fin_round = 1'b0;
    eu_sum    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && in_op == OP_STEP) begin
          acc_clr   = 1'b1;
          row_nxt   = '0;
          term_nxt  = '0;
          phase_nxt = (no_cnt == '0) ? PH_STATE : PH_OUT;
          state_nxt = ST_ROW_ISSUE;
        end
      end
      ST_ROW_ISSUE: begin
        issue = 1'b1;
        if (term_last) begin
          term_nxt  = '0;
          state_nxt = ST_ROW_DRAIN;
        end else begin
          term_nxt = term_r + TERM_W'(1);
        end
      end
      ST_ROW_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        fin_round = 1'b1;
        if (phase_r == PH_STATE && cfg_euler_r) begin
          state_nxt = ST_EU_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EU_MUL: begin
        state_nxt = ST_EU_SUM;
      end
      ST_EU_SUM: begin
        eu_sum    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (row_last) begin
            if (phase_r == PH_OUT) begin
              phase_nxt = PH_STATE;
              row_nxt   = '0;
              acc_clr   = 1'b1;
              state_nxt = ST_ROW_ISSUE;
            end else begin
              cp_nxt    = '0;
              state_nxt = ST_COPY;
            end
          end else begin
            row_nxt   = row_r + IDX_W'(1);
            acc_clr   = 1'b1;
            state_nxt = ST_ROW_ISSUE;
          end
        end
      end
      ST_COPY: begin
        if (cp_last) begin
          state_nxt = ST_COPY_END;
        end else begin
          cp_nxt = cp_r + IDX_W'(1);
        end
      end
      ST_COPY_END: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      phase_r   <= PH_OUT;
      row_r     <= '0;
      term_r    <= '0;
      cp_r      <= '0;
      cp_v_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_r + COEF_AW'(1);
      phase_r   <= phase_nxt;
      row_r     <= row_nxt;
      term_r    <= term_nxt;
      cp_r      <= cp_nxt;
      cp_v_r    <= (state_r == ST_COPY);
      v1_r      <= issue;
      v2_r      <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cp_idx_r <= cp_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_states_r  <= 4'd8;
      cfg_inputs_r  <= 3'd0;
      cfg_outputs_r <= 3'd0;
      cfg_euler_r   <= 1'b0;
      cfg_step_r    <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STATES:  cfg_states_r  <= cfg_data[3:0];
        REG_INPUTS:  cfg_inputs_r  <= cfg_data[2:0];
        REG_OUTPUTS: cfg_outputs_r <= cfg_data[2:0];
        REG_EULER:   cfg_euler_r   <= cfg_data[0];
        REG_STEP:    cfg_step_r    <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient memory ports.
  assign coef_raddr = {term_mat, row_r, term_col};

  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = {in_sel, in_row, in_col};
    coef_wdata = in_val;
    if (state_r == ST_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_cnt_r;
      coef_wdata = '0;
    end else if (in_accept && in_op == OP_LOAD_COEF) begin
      coef_we = coef_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_q_r <= coef_mem[coef_raddr];
  end

  // Vector memory ports: inputs, current state and the staged next state.
  always_comb begin
    case (state_r)
      ST_FIN, ST_EU_MUL, ST_EU_SUM: vec_raddr = {VR_STATE, row_r};
      ST_COPY:                      vec_raddr = {VR_STAGE, cp_r};
      default: begin
        vec_raddr = term_is_state ? {VR_STATE, term_r[IDX_W-1:0]}
                                  : {VR_INPUT, in_idx[IDX_W-1:0]};
      end
    endcase
  end

  always_comb begin
    vec_we    = 1'b0;
    vec_waddr = {VR_STATE, in_row};
    vec_wdata = in_val;
    if (state_r == ST_CLEAR) begin
      vec_we    = 1'b1;
      vec_waddr = clr_cnt_r[VEC_AW-1:0];
      vec_wdata = '0;
    end else if (cp_v_r) begin
      vec_we    = 1'b1;
      vec_waddr = {VR_STATE, cp_idx_r};
      vec_wdata = vec_q_r;
    end else if (out_load && phase_r == PH_STATE) begin
      vec_we    = 1'b1;
      vec_waddr = {VR_STAGE, row_r};
      vec_wdata = res_value_r;
    end else if (in_accept && in_op == OP_WRITE_INPUT) begin
      vec_we    = ({1'b0, in_row} < CNT_W'(MAX_INPUTS));
      vec_waddr = {VR_INPUT, in_row};
    end else if (in_accept && in_op == OP_WRITE_STATE) begin
      vec_we    = ({1'b0, in_row} < CNT_W'(MAX_STATES));
      vec_waddr = {VR_STATE, in_row};
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_q_r <= vec_mem[vec_raddr];
  end

  // Multiply-accumulate: the sum of a row never reaches the accumulator's range.
  always_ff @(posedge clk) begin
    prod_r <= coef_q_r * vec_q_r;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // Round half up: add one half and drop the fraction with floor.
  assign rnd_sum  = {acc_r[ACC_W-1], acc_r} + RND_HALF;
  assign rnd      = rnd_sum[ACC_W:FRAC_BITS];
  assign clip_rnd = clip_value({{(CLIP_W - RND_W){rnd[RND_W-1]}}, rnd});

  // Euler update: x * 2^16 + dt * dx, rounded by the step's 16 fraction bits.
  assign eu_t = {{(T_W - VALUE_WIDTH - STEP_FRAC){vec_q_r[VALUE_WIDTH-1]}}, vec_q_r,
                 {STEP_FRAC{1'b0}}}
              + {eprod_r[EPROD_W-1], eprod_r}
              + STEP_HALF;
  assign eu_v    = eu_t[T_W-1:STEP_FRAC];
  assign clip_eu = clip_value(eu_v);

  always_ff @(posedge clk) begin
    if (fin_round) begin
      dx_r        <= rnd;
      res_value_r <= clip_rnd.value;
      res_sat_r   <= clip_rnd.sat;
    end else if (eu_sum) begin
      res_value_r <= clip_eu.value;
      res_sat_r   <= clip_eu.sat;
    end
    eprod_r <= $signed({1'b0, cfg_step_r}) * dx_r;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {4'b0000, res_sat_r, res_value_r, row_r};
      out_kind_r  <= phase_r;
      out_last_r  <= (phase_r == PH_STATE) && row_last;
    end
  end

  // A new word never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result word overwritten before it was taken");

  // The copy-back and the staging write share the vector port and must never meet.
  a_vec_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cp_v_r && out_load && phase_r == PH_STATE))
    else $error("vector memory write collision");

  // No word is taken while the MAC pipeline or the copy-back is still busy.
  a_quiet_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (!v1_r && !v2_r && !cp_v_r))
    else $error("input taken while a step is still in flight");

  // The accumulator only takes products while a row is being summed.
  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == ST_ROW_ISSUE || state_r == ST_ROW_DRAIN))
    else $error("product accumulated outside a row");

endmodule
